// ----- src/glzw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_pkg: shared types and constants of the GIF LZW encoder
// Payload structs of both channels, the packer command and the fixed codes
// of the GIF LZW scheme for 8-bit palette indices.
// ----------------------------------------------------------------------------
package glzw_pkg;

	localparam int DICT_AW    = 20;
	localparam int DICT_DEPTH = 1 << DICT_AW;
	localparam int CODE_W     = 12;
	localparam int NF_W       = 13;
	localparam int CW_W       = 4;

	localparam logic [CODE_W-1:0] CODE_CLEAR = 12'd256;
	localparam logic [CODE_W-1:0] CODE_END   = 12'd257;
	localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;

	localparam logic [CW_W-1:0] MIN_WIDTH = 4'd9;
	localparam logic [CW_W-1:0] MAX_WIDTH = 4'd12;

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_END   = 1'b1;

	typedef struct packed {
		logic       action;
		logic [7:0] pixel;
	} pix_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_step;
		logic       frame_done;
	} byte_t;

	typedef struct packed {
		logic [CODE_W-1:0] code_a;
		logic [CW_W-1:0]   width_a;
		logic              has_b;
		logic [CODE_W-1:0] code_b;
		logic [CW_W-1:0]   width_b;
		logic              flush;
	} pack_cmd_t;

endpackage

// ----- src/glzw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_ram: generic simple dual-port RAM
// One write port, one read port with enable and registered data. A read of
// the address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module glzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/glzw_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glzw_packer: LSB-first code packer
// Merges up to two codes of one step into the residual bits, then hands
// out the finished bytes one per transfer, marking the last byte of the step.
// ----------------------------------------------------------------------------
module glzw_packer (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  glzw_pkg::pack_cmd_t  cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output glzw_pkg::byte_t      out_data
);
	import glzw_pkg::*;

	logic [6:0]  acc_q;
	logic [2:0]  held_q;
	logic [31:0] buf_q;
	logic [2:0]  cnt_q;
	logic        done_q;

	logic [31:0] word;
	logic [4:0]  tot;
	logic [4:0]  pos_b;
	logic [2:0]  nbytes;
	logic        take;
	logic        xfer;

	always_comb begin
		pos_b = 5'(held_q) + 5'(cmd.width_a);
		word  = 32'(acc_q) | (32'(cmd.code_a) << held_q);
		tot   = pos_b;
		if (cmd.has_b) begin
			word = word | (32'(cmd.code_b) << pos_b);
			tot  = pos_b + 5'(cmd.width_b);
		end
		nbytes = {1'b0, tot[4:3]};
		if (cmd.flush && tot[2:0] != 3'd0) begin
			nbytes = nbytes + 3'd1;
		end
	end

	assign xfer      = out_valid && out_ready;
	assign cmd_ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_ready);
	assign take      = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (take) begin
			cnt_q  <= nbytes;
			done_q <= cmd.flush;
			if (cmd.flush) begin
				acc_q  <= '0;
				held_q <= '0;
			end else begin
				// keep the partial byte above the full ones
				acc_q  <= word[{tot[4:3], 3'b000} +: 7];
				held_q <= tot[2:0];
			end
		end else if (xfer) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= word;
		end else if (xfer) begin
			buf_q <= {8'h00, buf_q[31:8]};
		end
	end

	assign out_valid             = cnt_q != 3'd0;
	assign out_data.out_byte     = buf_q[7:0];
	assign out_data.last_of_step = cnt_q == 3'd1;
	assign out_data.frame_done   = done_q && cnt_q == 3'd1;

endmodule

// ----- src/gif_lzw_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_encoder: GIF LZW code stream encoder for 8-bit palette indices
// Turns the pixels of a frame into the packed LZW byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel: action 0 carries one palette index, action 1 ends the
//   frame and flushes. byte channel: packed code stream, LSB first, with
//   last_of_step on the final byte an item caused and frame_done on the
//   final byte of the frame.
//   A new item is not taken while one is in stage 1: the dictionary read
//   (address built from the current prefix) is followed by a read of the
//   code-to-pair map that confirms the entry; the next item's address needs
//   that result. The packer registers an item's bytes after its stage 2 decision;
//   an item yields 0 to 4 bytes, one per cycle while byte_ready is high.
//   Reset: the dictionary needs no clearing pass. An entry counts only when
//   its code lies in the current table range and the map points back to
//   the same (prefix, pixel) pair, so a table reset is a counter reset.
//   A stalled byte receiver backs up into the packer; once the packer's
//   bytes cannot drain, decisions that emit codes wait and pixel_ready drops.
// ----------------------------------------------------------------------------
module gif_lzw_encoder #(
	parameter int MAX_CODES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_ready,
	input  glzw_pkg::pix_t   pixel_data,
	output logic             byte_valid,
	input  logic             byte_ready,
	output glzw_pkg::byte_t  byte_data
);
	import glzw_pkg::*;

	localparam int RAW = $clog2(MAX_CODES);
	localparam logic [NF_W-1:0] NF_MAX = NF_W'(MAX_CODES);

	// architectural state
	logic [CODE_W-1:0] prefix_q;
	logic              open_q;
	logic [NF_W-1:0]   nf_q;
	logic [CW_W-1:0]   width_q;

	// pipeline
	logic               valid_s1;
	pix_t               item_s1;
	logic [DICT_AW-1:0] addr_s1;
	logic               fwd_s1;
	logic [CODE_W-1:0]  fwd_code_s1;
	logic               valid_s2;
	pix_t               item_s2;
	logic [DICT_AW-1:0] addr_s2;
	logic [CODE_W-1:0]  code_s2;

	logic               accept;
	logic               commit;
	logic               need_cmd;
	logic               add_entry;
	logic               hit;
	logic               dict_we;
	logic [DICT_AW-1:0] dict_raddr;
	logic [CODE_W-1:0]  dict_rdata;
	logic [CODE_W-1:0]  code_s1;
	logic [DICT_AW-1:0] rev_rdata;
	logic [CODE_W-1:0]  prefix_d;
	logic [CODE_W-1:0]  prefix_next;
	logic               open_d;
	logic [NF_W-1:0]    nf_d;
	logic [NF_W-1:0]    nf_inc;
	logic [CW_W-1:0]    width_d;
	pack_cmd_t          cmd;
	logic               cmd_valid;
	logic               cmd_ready;

	// decision for the item in stage 2
	always_comb begin
		need_cmd  = 1'b0;
		add_entry = 1'b0;
		hit       = 1'b0;
		cmd       = '0;
		prefix_d  = prefix_q;
		open_d    = open_q;
		nf_d      = nf_q;
		width_d   = width_q;
		nf_inc    = nf_q + NF_W'(1);
		if (item_s2.action == ACT_END) begin
			need_cmd    = 1'b1;
			cmd.code_a  = CODE_CLEAR;
			if (open_q) begin
				cmd.code_a = prefix_q;
			end
			cmd.width_a = width_q;
			cmd.has_b   = 1'b1;
			cmd.code_b  = CODE_END;
			cmd.width_b = width_q;
			cmd.flush   = 1'b1;
			prefix_d    = '0;
			open_d      = 1'b0;
			nf_d        = {1'b0, FIRST_FREE};
			width_d     = MIN_WIDTH;
		end else if (!open_q) begin
			need_cmd    = 1'b1;
			cmd.code_a  = CODE_CLEAR;
			cmd.width_a = MIN_WIDTH;
			prefix_d    = {4'h0, item_s2.pixel};
			open_d      = 1'b1;
			nf_d        = {1'b0, FIRST_FREE};
			width_d     = MIN_WIDTH;
		end else begin
			// trust the entry only if its code is live and maps back to this pair
			if (code_s2 >= FIRST_FREE && {1'b0, code_s2} < nf_q) begin
				if (rev_rdata == addr_s2) begin
					hit = 1'b1;
				end
			end
			if (hit) begin
				prefix_d = code_s2;
			end else begin
				need_cmd    = 1'b1;
				cmd.code_a  = prefix_q;
				cmd.width_a = width_q;
				prefix_d    = {4'h0, item_s2.pixel};
				if (nf_q < NF_MAX) begin
					add_entry = 1'b1;
					nf_d      = nf_inc;
					if (nf_inc > (NF_W'(1) << width_q) && width_q < MAX_WIDTH) begin
						width_d = width_q + CW_W'(1);
					end
				end else begin
					cmd.has_b   = 1'b1;
					cmd.code_b  = CODE_CLEAR;
					cmd.width_b = width_q;
					nf_d        = {1'b0, FIRST_FREE};
					width_d     = MIN_WIDTH;
				end
			end
		end
	end

	assign cmd_valid   = valid_s2 && need_cmd;
	assign commit      = valid_s2 && (!need_cmd || cmd_ready);
	assign dict_we     = commit && add_entry;
	assign pixel_ready = !valid_s1 && (!valid_s2 || commit);
	assign accept      = pixel_valid && pixel_ready;

	// forward the prefix that commits in this cycle into the next lookup
	always_comb begin
		prefix_next = prefix_q;
		if (commit) begin
			prefix_next = prefix_d;
		end
	end

	assign dict_raddr = {prefix_next, pixel_data.pixel};

	always_comb begin
		code_s1 = dict_rdata;
		if (fwd_s1) begin
			code_s1 = fwd_code_s1;
		end
	end

	glzw_ram #(
		.WIDTH(CODE_W),
		.DEPTH(DICT_DEPTH)
	) u_dict (
		.clk  (clk),
		.we   (dict_we),
		.waddr(addr_s2),
		.wdata(nf_q[CODE_W-1:0]),
		.re   (accept),
		.raddr(dict_raddr),
		.rdata(dict_rdata)
	);

	glzw_ram #(
		.WIDTH(DICT_AW),
		.DEPTH(MAX_CODES)
	) u_rev (
		.clk  (clk),
		.we   (dict_we),
		.waddr(nf_q[RAW-1:0]),
		.wdata(addr_s2),
		.re   (valid_s1),
		.raddr(code_s1[RAW-1:0]),
		.rdata(rev_rdata)
	);

	glzw_packer u_packer (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.out_valid(byte_valid),
		.out_ready(byte_ready),
		.out_data (byte_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fwd_s1   <= 1'b0;
			prefix_q <= '0;
			open_q   <= 1'b0;
			nf_q     <= {1'b0, FIRST_FREE};
			width_q  <= MIN_WIDTH;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				// read-first RAM: take the written code when addresses collide
				fwd_s1 <= dict_we && (addr_s2 == dict_raddr);
			end
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (commit) begin
				valid_s2 <= 1'b0;
			end
			if (commit) begin
				prefix_q <= prefix_d;
				open_q   <= open_d;
				nf_q     <= nf_d;
				width_q  <= width_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= pixel_data;
			addr_s1     <= dict_raddr;
			fwd_code_s1 <= nf_q[CODE_W-1:0];
		end
		if (valid_s1) begin
			item_s2 <= item_s1;
			addr_s2 <= addr_s1;
			code_s2 <= code_s1;
		end
	end

	// stage 1 never stalls
	a_s1_advances: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2)
		else $error("stage 1 item did not reach stage 2");

	// code width keeps pace with the table fill
	a_width_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= NF_MAX && (nf_q <= (NF_W'(1) << width_q) || width_q == MAX_WIDTH))
		else $error("code width out of step with next free code");

	// every new entry consumes exactly one code
	a_entry_counts: assert property (@(posedge clk) disable iff (!arst_n)
		dict_we |=> nf_q == $past(nf_q) + NF_W'(1))
		else $error("dictionary write without code allocation");

endmodule
